// ===== rtl/core/mae_pkg.sv =====
`timescale 1ns / 1ps

package mae_pkg;

    // Datapath widths
    localparam int WORD_BITS      = 52;
    localparam int HALF_BITS      = WORD_BITS / 2;
    localparam int PROD_BITS      = 2 * WORD_BITS;
    localparam int Q_BITS         = 50;
    localparam int A_BITS         = 64;
    localparam int MODE_BITS      = 4;
    localparam int SHIFT_BITS     = 6;
    localparam int CFG_INDEX_BITS = 2;

    // Stream packing
    localparam int IN_MODE_LSB    = 0;
    localparam int IN_A_LSB       = IN_MODE_LSB + MODE_BITS;
    localparam int IN_B_LSB       = IN_A_LSB + A_BITS;
    localparam int IN_ACC_LSB     = IN_B_LSB + Q_BITS;
    localparam int IN_DATA_BITS   = IN_ACC_LSB + Q_BITS;
    localparam int OUT_DATA_BITS  = ((Q_BITS + 7) / 8) * 8;

    // Pipeline stage numbers
    localparam int ST_MUL1_PP     = 1;
    localparam int ST_MUL1_SUM    = 2;
    localparam int ST_SHIFT       = 3;
    localparam int ST_MUL2_PP     = 4;
    localparam int ST_MUL2_SUM    = 5;
    localparam int ST_MUL3_PP     = 6;
    localparam int ST_MUL3_SUM    = 7;
    localparam int ST_DIFF        = 8;
    localparam int ST_FOLD        = 9;
    localparam int ST_COMB        = 10;
    localparam int ST_OUT         = 11;
    localparam int PIPE_DEPTH     = ST_OUT;

    localparam logic [Q_BITS-1:0] MODULUS_RESET = Q_BITS'(2);

    typedef enum logic [MODE_BITS-1:0] {
        MODE_MUL       = 4'd0,
        MODE_MULADD    = 4'd1,
        MODE_MULSUB    = 4'd2,
        MODE_SCALE     = 4'd3,
        MODE_FMA       = 4'd4,
        MODE_ADDSCALAR = 4'd5,
        MODE_SUBSCALAR = 4'd6,
        MODE_NEG       = 4'd7,
        MODE_ADD       = 4'd8,
        MODE_SUB       = 4'd9,
        MODE_REDUCE    = 4'd10,
        MODE_REDUCE_S  = 4'd11
    } mode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MODULUS = 2'd0,
        REG_BARRETT = 2'd1,
        REG_SHIFT   = 2'd2,
        REG_SCALAR  = 2'd3
    } reg_index_t;

    // What feeds the final correction stage
    typedef enum logic [2:0] {
        SRC_ZERO    = 3'd0,
        SRC_WORD    = 3'd1,
        SRC_MOD     = 3'd2,
        SRC_ACC_ADD = 3'd3,
        SRC_ACC_SUB = 3'd4
    } src_t;

    // Final correction against q
    typedef enum logic [1:0] {
        FIX_PASS  = 2'd0,
        FIX_CSUB  = 2'd1,
        FIX_ADDQ  = 2'd2,
        FIX_NEGNZ = 2'd3
    } fix_t;

    typedef struct packed {
        logic first;
        logic second;
    } stage_en_t;

    typedef struct packed {
        src_t              src;
        fix_t              fix;
        logic              is_mul;
        logic [Q_BITS-1:0] acc;
        logic              last;
        logic [A_BITS-1:0] word;
    } side_t;

endpackage

// ===== rtl/core/mae_mul52.sv =====
`timescale 1ns / 1ps

module mae_mul52
    import mae_pkg::*;
(
    input  logic                 clk,
    input  stage_en_t            en,
    input  logic [WORD_BITS-1:0] x,
    input  logic [WORD_BITS-1:0] y,
    output logic [PROD_BITS-1:0] product
);

    logic [WORD_BITS-1:0] pp_ll_next, pp_lh_next, pp_hl_next, pp_hh_next;
    logic [WORD_BITS-1:0] pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic [PROD_BITS-1:0] product_next, product_reg;

    // four half-width partial products, summed in the next stage
    assign pp_ll_next = WORD_BITS'(x[HALF_BITS-1:0]) * WORD_BITS'(y[HALF_BITS-1:0]);
    assign pp_lh_next = WORD_BITS'(x[HALF_BITS-1:0]) * WORD_BITS'(y[WORD_BITS-1:HALF_BITS]);
    assign pp_hl_next = WORD_BITS'(x[WORD_BITS-1:HALF_BITS]) * WORD_BITS'(y[HALF_BITS-1:0]);
    assign pp_hh_next = WORD_BITS'(x[WORD_BITS-1:HALF_BITS]) * WORD_BITS'(y[WORD_BITS-1:HALF_BITS]);

    assign product_next = PROD_BITS'(pp_ll_reg)
                        + (PROD_BITS'(pp_lh_reg) << HALF_BITS)
                        + (PROD_BITS'(pp_hl_reg) << HALF_BITS)
                        + (PROD_BITS'(pp_hh_reg) << WORD_BITS);

    always_ff @(posedge clk)
    begin
        if (en.first)
        begin
            pp_ll_reg <= pp_ll_next;
            pp_lh_reg <= pp_lh_next;
            pp_hl_reg <= pp_hl_next;
            pp_hh_reg <= pp_hh_next;
        end
        if (en.second)
        begin
            product_reg <= product_next;
        end
    end

    assign product = product_reg;

endmodule

// ===== rtl/core/mae_post.sv =====
`timescale 1ns / 1ps

module mae_post
    import mae_pkg::*;
(
    input  logic                 clk,
    input  stage_en_t            en,
    input  side_t                side,
    input  logic [WORD_BITS-1:0] m,
    input  logic [Q_BITS-1:0]    modulus,
    output logic [Q_BITS-1:0]    result,
    output logic                 last
);

    logic [A_BITS-1:0] val_next, val_reg;
    fix_t              fix_reg;
    logic              last_c_reg;
    logic [A_BITS:0]   csub_diff;
    logic [Q_BITS-1:0] result_next, result_reg;
    logic              last_reg;

    always_comb
    begin
        case (side.src)
            SRC_ZERO:    val_next = '0;
            SRC_WORD:    val_next = side.word;
            SRC_MOD:     val_next = A_BITS'(m);
            SRC_ACC_ADD: val_next = A_BITS'(side.acc) + A_BITS'(m);
            SRC_ACC_SUB: val_next = A_BITS'(side.acc) - A_BITS'(m);
            default:     val_next = '0;
        endcase
    end

    // borrow out of val - q means val < q
    assign csub_diff = {1'b0, val_reg} - (A_BITS + 1)'(modulus);

    always_comb
    begin
        case (fix_reg)
            FIX_PASS:
                result_next = val_reg[Q_BITS-1:0];
            FIX_CSUB:
                result_next = csub_diff[A_BITS] ? val_reg[Q_BITS-1:0] : csub_diff[Q_BITS-1:0];
            FIX_ADDQ:
                result_next = val_reg[A_BITS-1] ? val_reg[Q_BITS-1:0] + modulus
                                                : val_reg[Q_BITS-1:0];
            FIX_NEGNZ:
                result_next = (val_reg == '0) ? '0 : modulus - val_reg[Q_BITS-1:0];
            default:
                result_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en.first)
        begin
            val_reg    <= val_next;
            fix_reg    <= side.fix;
            last_c_reg <= side.last;
        end
        if (en.second)
        begin
            result_reg <= result_next;
            last_reg   <= last_c_reg;
        end
    end

    assign result = result_reg;
    assign last   = last_reg;

endmodule

// ===== rtl/core/modular_elementwise_alu.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tdata: mode, operand_a, operand_b, accumulator;
//                                       tlast: last_element
// m_axis    out  tvalid/tready          tdata: result; tlast: last
// cfg       in   cfg_we (no wait)       cfg_index, cfg_wdata
//
// One element per cycle sustained while m_axis_tready stays high; a stalled output holds the stages.
// The pipeline holds three 52-bit multipliers in series (product, quotient estimate,
// quotient times q), each split into a partial-product and a summing stage.
// Reset clears the stage valid bits and loads the register defaults; no clearing pass.
// Each stage holds while its successor is full and stalled; empty stages close up.

module modular_elementwise_alu
    import mae_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]      cfg_wdata,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // mode[3:0], operand_a[67:4], operand_b[117:68], accumulator[167:118]
    input  logic [IN_DATA_BITS-1:0]   s_axis_tdata,
    input  logic                      s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // result[49:0], zero fill [55:50]
    output logic [OUT_DATA_BITS-1:0]  m_axis_tdata,
    output logic                      m_axis_tlast
);

    logic [Q_BITS-1:0]     modulus_reg;
    logic [WORD_BITS-1:0]  barrett_reg;
    logic [SHIFT_BITS-1:0] shift_reg;
    logic [Q_BITS-1:0]     scalar_reg;

    logic [PIPE_DEPTH:1]   valid_reg, valid_next, stage_en, valid_in;

    logic [MODE_BITS-1:0]  in_mode;
    logic [A_BITS-1:0]     in_a;
    logic [Q_BITS-1:0]     in_b, in_acc;
    logic [WORD_BITS-1:0]  mul_y;
    side_t                 side_next;
    side_t                 side_reg [ST_MUL1_PP:ST_FOLD];

    logic [PROD_BITS-1:0]  prod1, prod2, prod3;
    logic [PROD_BITS-1:0]  barrett_src, shifted;
    logic [WORD_BITS-1:0]  c1_next, c1_reg;
    logic [WORD_BITS-1:0]  low_reg [ST_SHIFT:ST_MUL3_SUM];
    logic [WORD_BITS-1:0]  v_next, v_reg, m_next, m_reg;
    logic [WORD_BITS:0]    fold_diff;
    logic [Q_BITS-1:0]     result;
    logic                  result_last;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
            barrett_reg <= '0;
            shift_reg   <= '0;
            scalar_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_MODULUS: modulus_reg <= cfg_wdata[Q_BITS-1:0];
                REG_BARRETT: barrett_reg <= cfg_wdata;
                REG_SHIFT:   shift_reg   <= cfg_wdata[SHIFT_BITS-1:0];
                REG_SCALAR:  scalar_reg  <= cfg_wdata[Q_BITS-1:0];
            endcase
        end
    end

    // stage enables: a stage loads when it is empty or its content moves on
    always_comb
    begin
        stage_en[PIPE_DEPTH] = !valid_reg[PIPE_DEPTH] || m_axis_tready;
        for (int k = PIPE_DEPTH - 1; k >= 1; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k + 1];
        end
    end

    assign valid_in   = {valid_reg[PIPE_DEPTH-1:1], s_axis_tvalid};
    assign valid_next = (stage_en & valid_in) | (~stage_en & valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_axis_tready = stage_en[ST_MUL1_PP];
    assign m_axis_tvalid = valid_reg[ST_OUT];

    // input decode
    assign in_mode = s_axis_tdata[IN_MODE_LSB +: MODE_BITS];
    assign in_a    = s_axis_tdata[IN_A_LSB +: A_BITS];
    assign in_b    = s_axis_tdata[IN_B_LSB +: Q_BITS];
    assign in_acc  = s_axis_tdata[IN_ACC_LSB +: Q_BITS];

    always_comb
    begin
        mul_y            = WORD_BITS'(in_b);
        side_next.src    = SRC_ZERO;
        side_next.fix    = FIX_PASS;
        side_next.is_mul = 1'b0;
        side_next.acc    = in_acc;
        side_next.last   = s_axis_tlast;
        side_next.word   = in_a;
        unique case (mode_t'(in_mode))
            MODE_MUL:
            begin
                side_next.src    = SRC_MOD;
                side_next.is_mul = 1'b1;
            end
            MODE_MULADD:
            begin
                side_next.src    = SRC_ACC_ADD;
                side_next.fix    = FIX_CSUB;
                side_next.is_mul = 1'b1;
            end
            MODE_MULSUB:
            begin
                side_next.src    = SRC_ACC_SUB;
                side_next.fix    = FIX_ADDQ;
                side_next.is_mul = 1'b1;
            end
            MODE_SCALE:
            begin
                mul_y            = WORD_BITS'(scalar_reg);
                side_next.src    = SRC_MOD;
                side_next.is_mul = 1'b1;
            end
            MODE_FMA:
            begin
                mul_y            = WORD_BITS'(scalar_reg);
                side_next.src    = SRC_ACC_ADD;
                side_next.fix    = FIX_CSUB;
                side_next.is_mul = 1'b1;
            end
            MODE_ADDSCALAR:
            begin
                side_next.src  = SRC_WORD;
                side_next.fix  = FIX_CSUB;
                side_next.word = in_a + A_BITS'(scalar_reg);
            end
            MODE_SUBSCALAR:
            begin
                side_next.src  = SRC_WORD;
                side_next.fix  = FIX_ADDQ;
                side_next.word = in_a - A_BITS'(scalar_reg);
            end
            MODE_NEG:
            begin
                side_next.src = SRC_WORD;
                side_next.fix = FIX_NEGNZ;
            end
            MODE_ADD:
            begin
                side_next.src  = SRC_WORD;
                side_next.fix  = FIX_CSUB;
                side_next.word = in_a + A_BITS'(in_b);
            end
            MODE_SUB:
            begin
                side_next.src  = SRC_WORD;
                side_next.fix  = FIX_ADDQ;
                side_next.word = in_a - A_BITS'(in_b);
            end
            MODE_REDUCE:
            begin
                side_next.src = SRC_MOD;
            end
            MODE_REDUCE_S:
            begin
                // reduce the magnitude, then negate a nonzero remainder
                side_next.src  = SRC_MOD;
                side_next.fix  = in_a[A_BITS-1] ? FIX_NEGNZ : FIX_PASS;
                side_next.word = in_a[A_BITS-1] ? A_BITS'(0) - in_a : in_a;
            end
            default:
            begin
                side_next.src = SRC_ZERO;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[ST_MUL1_PP])
        begin
            side_reg[ST_MUL1_PP] <= side_next;
        end
        for (int k = ST_MUL1_PP + 1; k <= ST_FOLD; k++)
        begin
            if (stage_en[k])
            begin
                side_reg[k] <= side_reg[k - 1];
            end
        end
    end

    // operand product
    mae_mul52 u_mul_ab (
        .clk     (clk),
        .en      ({stage_en[ST_MUL1_PP], stage_en[ST_MUL1_SUM]}),
        .x       (in_a[WORD_BITS-1:0]),
        .y       (mul_y),
        .product (prod1)
    );

    // Barrett input: the product shifted, or the 64-bit word for the reduce modes.
    // For products a shift above the word width leaves only the low half, which is gone.
    assign barrett_src = side_reg[ST_MUL1_SUM].is_mul ? prod1
                                                      : PROD_BITS'(side_reg[ST_MUL1_SUM].word);
    assign shifted     = barrett_src >> shift_reg;
    assign c1_next     = (side_reg[ST_MUL1_SUM].is_mul && shift_reg > SHIFT_BITS'(WORD_BITS))
                       ? '0 : shifted[WORD_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (stage_en[ST_SHIFT])
        begin
            c1_reg            <= c1_next;
            low_reg[ST_SHIFT] <= barrett_src[WORD_BITS-1:0];
        end
        for (int k = ST_SHIFT + 1; k <= ST_MUL3_SUM; k++)
        begin
            if (stage_en[k])
            begin
                low_reg[k] <= low_reg[k - 1];
            end
        end
    end

    // quotient estimate: high half of c1 * factor
    mae_mul52 u_mul_qhat (
        .clk     (clk),
        .en      ({stage_en[ST_MUL2_PP], stage_en[ST_MUL2_SUM]}),
        .x       (c1_reg),
        .y       (barrett_reg),
        .product (prod2)
    );

    // quotient times q, low half only is used
    mae_mul52 u_mul_qq (
        .clk     (clk),
        .en      ({stage_en[ST_MUL3_PP], stage_en[ST_MUL3_SUM]}),
        .x       (prod2[PROD_BITS-1:WORD_BITS]),
        .y       (WORD_BITS'(modulus_reg)),
        .product (prod3)
    );

    assign v_next    = low_reg[ST_MUL3_SUM] - prod3[WORD_BITS-1:0];
    assign fold_diff = {1'b0, v_reg} - (WORD_BITS + 1)'(modulus_reg);
    assign m_next    = fold_diff[WORD_BITS] ? v_reg : fold_diff[WORD_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (stage_en[ST_DIFF])
        begin
            v_reg <= v_next;
        end
        if (stage_en[ST_FOLD])
        begin
            m_reg <= m_next;
        end
    end

    mae_post u_post (
        .clk     (clk),
        .en      ({stage_en[ST_COMB], stage_en[ST_OUT]}),
        .side    (side_reg[ST_FOLD]),
        .m       (m_reg),
        .modulus (modulus_reg),
        .result  (result),
        .last    (result_last)
    );

    assign m_axis_tdata = {{(OUT_DATA_BITS - Q_BITS){1'b0}}, result};
    assign m_axis_tlast = result_last;

endmodule

// ===== tb/modular_elementwise_alu_tb.sv =====
`timescale 1ns / 1ps

module modular_elementwise_alu_tb;
    import mae_pkg::*;

    localparam int IDLE_PCT      = 27;
    localparam int SETTLE_CYCLES = PIPE_DEPTH + 4;
    localparam int STALL_LIMIT   = 5000;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [63:0] Q_MAX = (64'd1 << Q_BITS) - 64'd1;

    typedef struct packed {
        logic [Q_BITS-1:0] value;
        logic              is_last;
    } mod_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_MODULUS;
    logic [WORD_BITS-1:0]      cfg_wdata = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    // mode, operand_a, operand_b, accumulator
    logic [IN_DATA_BITS-1:0]   s_axis_tdata = '0;
    logic                      s_axis_tlast = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // result, zero fill
    logic [OUT_DATA_BITS-1:0]  m_axis_tdata;
    logic                      m_axis_tlast;

    // Register copies for prediction
    logic [Q_BITS-1:0]         q_cur = MODULUS_RESET;
    logic [WORD_BITS-1:0]      factor_cur = '0;
    logic [SHIFT_BITS-1:0]     shift_cur = '0;
    logic [Q_BITS-1:0]         scalar_cur = '0;

    mod_result_t               pending_results[$];
    int unsigned               mismatch_count = 0;
    int unsigned               quiet_cycles = 0;
    bit                        steady_flow = 1'b0;

    modular_elementwise_alu DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ---------------------------------------------------------------- prediction

    function automatic logic [PROD_BITS-1:0] wide_product(input logic [63:0] x,
                                                          input logic [63:0] y);
        return PROD_BITS'(x[WORD_BITS-1:0]) * PROD_BITS'(y[WORD_BITS-1:0]);
    endfunction

    function automatic logic [63:0] csub_q(input logic [63:0] v);
        logic [63:0] r;
        r = v - 64'(q_cur);
        return (r < v) ? r : v;
    endfunction

    function automatic logic [63:0] diff_q(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] d;
        d = x - y;
        return d[63] ? d + 64'(q_cur) : d;
    endfunction

    // quotient estimate from the shifted value, correction applied to the low word
    function automatic logic [63:0] barrett_fold(input logic [63:0] shifted,
                                                 input logic [63:0] low);
        logic [PROD_BITS-1:0] est;
        logic [PROD_BITS-1:0] corr;
        logic [WORD_BITS-1:0] sum;
        est  = wide_product(shifted, 64'(factor_cur));
        corr = wide_product(64'(est[PROD_BITS-1:WORD_BITS]), 64'(0) - 64'(q_cur));
        sum  = low[WORD_BITS-1:0] + corr[WORD_BITS-1:0];
        return csub_q(64'(sum));
    endfunction

    function automatic logic [63:0] mod_product(input logic [63:0] x, input logic [63:0] y);
        logic [PROD_BITS-1:0] p;
        logic [63:0]          lo;
        logic [63:0]          hi;
        logic [63:0]          folded;
        p      = wide_product(x, y);
        lo     = 64'(p[WORD_BITS-1:0]);
        hi     = 64'(p[PROD_BITS-1:WORD_BITS]);
        folded = lo >> shift_cur;
        // a shift past the word width leaves the high half out
        if (shift_cur <= WORD_BITS)
            folded = folded | (hi << (WORD_BITS - shift_cur));
        return barrett_fold(folded, lo);
    endfunction

    function automatic logic [63:0] reduce_word(input logic [63:0] v);
        return barrett_fold(v >> shift_cur, v);
    endfunction

    function automatic logic [Q_BITS-1:0] predict_result(input logic [MODE_BITS-1:0] mode,
                                                         input logic [63:0] a,
                                                         input logic [63:0] b,
                                                         input logic [63:0] acc);
        logic [63:0] q64;
        logic [63:0] s64;
        logic [63:0] r;
        logic [63:0] mag;
        q64 = 64'(q_cur);
        s64 = 64'(scalar_cur);
        case (mode)
            MODE_MUL:       r = mod_product(a, b);
            MODE_MULADD:    r = csub_q(acc + mod_product(a, b));
            MODE_MULSUB:    r = diff_q(acc, mod_product(a, b));
            MODE_SCALE:     r = mod_product(a, s64);
            MODE_FMA:       r = csub_q(acc + mod_product(a, s64));
            MODE_ADDSCALAR: r = csub_q(a + s64);
            MODE_SUBSCALAR: r = diff_q(a, s64);
            MODE_NEG:       r = (a == 64'd0) ? 64'd0 : q64 - a;
            MODE_ADD:       r = csub_q(a + b);
            MODE_SUB:       r = diff_q(a, b);
            MODE_REDUCE:    r = reduce_word(a);
            MODE_REDUCE_S:
            begin
                mag = a[63] ? 64'(0) - a : a;
                r = reduce_word(mag);
                if (a[63] && r != 64'd0)
                    r = q64 - r;
            end
            default:        r = '0;
        endcase
        return r[Q_BITS-1:0];
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic note_mismatch(input string what, input mod_result_t want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s: expected result %h last %b, got result %h last %b fill %h",
                     $time, what, want.value, want.is_last, m_axis_tdata[Q_BITS-1:0],
                     m_axis_tlast, m_axis_tdata[OUT_DATA_BITS-1:Q_BITS]);
    endtask

    always @(posedge clk)
    begin
        mod_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                want = '0;
                note_mismatch("transfer with no result pending", want);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[Q_BITS-1:0] !== want.value
                    || m_axis_tdata[OUT_DATA_BITS-1:Q_BITS] !== '0
                    || m_axis_tlast !== want.is_last)
                    note_mismatch("result differs", want);
            end
        end
    end

    always @(posedge clk)
        m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);

    // cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("modular_elementwise_alu: mismatch");
            $finish;
        end
        else
            quiet_cycles++;
    end

    // ---------------------------------------------------------------- stimulus

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_operand(input logic [63:0] bound);
        case ($urandom_range(0, 9))
            0:       return 64'd0;
            1:       return bound - 64'd1;
            default: return rand64() % bound;
        endcase
    endfunction

    task automatic send_element(input logic [MODE_BITS-1:0] mode, input logic [63:0] a,
                                input logic [63:0] b, input logic [63:0] acc,
                                input logic is_last);
        mod_result_t want;
        want.value   = predict_result(mode, a, b[Q_BITS-1:0], acc[Q_BITS-1:0]);
        want.is_last = is_last;
        if (!steady_flow && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {acc[Q_BITS-1:0], b[Q_BITS-1:0], a, mode};
        s_axis_tlast  <= is_last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(want);
    endtask

    // wild items take operands out of range
    task automatic send_random_elements(input int count, input int wild_pct);
        logic [MODE_BITS-1:0] mode;
        logic [63:0]          qm;
        logic [63:0]          a;
        logic [63:0]          b;
        logic [63:0]          acc;
        qm = 64'(q_cur);
        repeat (count)
        begin
            if ($urandom_range(0, 99) < 92)
                mode = MODE_BITS'($urandom_range(0, MODE_REDUCE_S));
            else
                mode = MODE_BITS'($urandom_range(MODE_REDUCE_S + 1, 2**MODE_BITS - 1));
            if ($urandom_range(0, 99) < wild_pct)
            begin
                a   = rand64() >> $urandom_range(0, 63);
                b   = rand64();
                acc = rand64();
            end
            else
            begin
                a   = pick_operand(qm);
                b   = pick_operand(qm);
                acc = pick_operand(qm);
                if (mode == MODE_REDUCE || mode == MODE_REDUCE_S)
                    a = $urandom_range(0, 1) ? rand64() : rand64() >> $urandom_range(1, 63);
            end
            send_element(mode, a, b, acc, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // block must be idle; all four registers are written in turn: modulus, factor, shift, scalar
    task automatic load_config(input logic [WORD_BITS-1:0] q_word,
                               input logic [WORD_BITS-1:0] factor,
                               input logic [WORD_BITS-1:0] shift_word,
                               input logic [WORD_BITS-1:0] scalar_word);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MODULUS;
        cfg_wdata <= q_word;
        @(posedge clk);
        cfg_index <= REG_BARRETT;
        cfg_wdata <= factor;
        @(posedge clk);
        cfg_index <= REG_SHIFT;
        cfg_wdata <= shift_word;
        @(posedge clk);
        cfg_index <= REG_SCALAR;
        cfg_wdata <= scalar_word;
        @(posedge clk);
        cfg_we     <= 1'b0;
        q_cur      = q_word[Q_BITS-1:0];
        factor_cur = factor;
        shift_cur  = shift_word[SHIFT_BITS-1:0];
        scalar_cur = scalar_word[Q_BITS-1:0];
    endtask

    // factor floor(2^(52+n-1)/q) for an n-bit q, shift n-1
    task automatic load_fitted(input logic [63:0] q, input logic [63:0] scalar);
        int unsigned          len;
        logic [127:0]         quo;
        logic [WORD_BITS-1:0] factor;
        len = $clog2(q + 64'd1);
        quo = (128'd1 << (WORD_BITS + len - 1)) / 128'(q);
        factor = quo[WORD_BITS-1:0];
        if (quo[127:WORD_BITS] != '0)
            factor = '1;
        load_config(q[WORD_BITS-1:0], factor, WORD_BITS'(len - 1), scalar[WORD_BITS-1:0]);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_reset_defaults();
        send_random_elements(20, 50);
        wait_for_results();
    endtask

    task automatic test_directed();
        logic [63:0] qm;
        load_fitted(Q_MAX, Q_MAX - 64'd1);
        qm = Q_MAX;
        send_element(MODE_MUL,       qm - 1, qm - 1, 0,      1'b0);
        send_element(MODE_MUL,       0,      0,      0,      1'b1);
        send_element(MODE_MULADD,    qm - 1, qm - 1, qm - 1, 1'b0);
        send_element(MODE_MULSUB,    1,      1,      0,      1'b0);
        send_element(MODE_SCALE,     qm - 1, 0,      0,      1'b1);
        send_element(MODE_FMA,       qm - 1, 0,      qm - 1, 1'b0);
        send_element(MODE_ADDSCALAR, qm - 1, 0,      0,      1'b0);
        send_element(MODE_SUBSCALAR, 0,      0,      0,      1'b1);
        // negation of zero stays zero
        send_element(MODE_NEG,       0,      0,      0,      1'b0);
        send_element(MODE_NEG,       1,      0,      0,      1'b1);
        send_element(MODE_ADD,       qm - 1, qm - 1, 0,      1'b0);
        send_element(MODE_SUB,       0,      qm - 1, 0,      1'b1);
        send_element(MODE_REDUCE,    '1,     0,      0,      1'b0);
        send_element(MODE_REDUCE,    0,      0,      0,      1'b1);
        send_element(MODE_REDUCE_S,  64'h8000_0000_0000_0000, 0, 0, 1'b0);
        send_element(MODE_REDUCE_S,  '1,     0,      0,      1'b0);
        // negative multiple of q: remainder zero, no q - r fix-up
        send_element(MODE_REDUCE_S,  64'(0) - qm, 0,  0,      1'b1);
        // only the low word of operand_a enters the multiplier
        send_element(MODE_MUL,       '1,     Q_MAX,  Q_MAX,  1'b0);
        send_element(MODE_ADD,       '1,     Q_MAX,  0,      1'b1);
        for (int m = int'(MODE_REDUCE_S) + 1; m < 2**MODE_BITS; m++)
            send_element(MODE_BITS'(m), rand64(), rand64(), rand64(), m[0]);
        wait_for_results();
    endtask

    task automatic test_random_moduli();
        int unsigned len;
        logic [63:0] q;
        for (int round = 0; round < 6; round++)
        begin
            len = $urandom_range(2, Q_BITS);
            q = (rand64() >> (64 - len)) | (64'd1 << (len - 1));
            load_fitted(q, rand64() % q);
            steady_flow = (round == 2);
            send_random_elements(110, 10);
            wait_for_results();
            steady_flow = 1'b0;
        end
    endtask

    task automatic test_small_moduli();
        load_fitted(64'd2, 64'd1);
        send_random_elements(60, 10);
        wait_for_results();
        load_fitted(64'd3, 64'd2);
        send_random_elements(60, 10);
        wait_for_results();
    endtask

    // factors and shifts that do not match q, junk above the register widths
    task automatic test_irregular_config();
        logic [WORD_BITS-1:0] factor;
        logic [WORD_BITS-1:0] shift_word;
        logic [63:0]          q;
        for (int round = 0; round < 4; round++)
        begin
            case (round)
                0:       begin factor = '0; shift_word = WORD_BITS'(WORD_BITS + 1); end
                1:       begin factor = '1; shift_word = '1; end
                2:       begin factor = WORD_BITS'(rand64()); shift_word = WORD_BITS'(WORD_BITS); end
                default: begin factor = WORD_BITS'(rand64()); shift_word = WORD_BITS'(rand64()); end
            endcase
            q = 64'd2 + rand64() % (Q_MAX - 64'd1);
            load_config({2'(rand64() >> 62), q[Q_BITS-1:0]}, factor, shift_word,
                        (round == 1) ? '1 : WORD_BITS'(rand64()));
            send_random_elements(100, 30);
            wait_for_results();
        end
    endtask

    initial
    begin
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed();
        test_random_moduli();
        test_small_moduli();
        test_irregular_config();
        if (mismatch_count == 0)
            $display("modular_elementwise_alu: match");
        else
            $display("modular_elementwise_alu: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mae_pkg.sv
rtl/core/mae_mul52.sv
rtl/core/mae_post.sv
rtl/core/modular_elementwise_alu.sv
tb/modular_elementwise_alu_tb.sv
